/* src/vcv_pkg.sv */
// ----------------------------------------------------------------------------
// vcv_pkg: shared definitions for the valid 2D convolution block
// Sizes, payload structs, register codes and the coefficient unpacking.
// ----------------------------------------------------------------------------
package vcv_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int MAX_WIDTH   = 64;
  localparam int LINES       = KERNEL_SIZE - 1;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;

  localparam int PIX_W       = 16;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WIDTH_W     = 7;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int PROD_W      = 2 * PIX_W;
  localparam int ROW_W       = PROD_W + $clog2(KERNEL_SIZE);
  localparam int SUM_W       = 40;
  localparam int LINE_WORD_W = LINES * PIX_W;

  typedef logic [PIX_W-1:0]            pix_t;
  typedef pix_t [KERNEL_SIZE-1:0]      column_t;
  typedef pix_t [TAPS-1:0]             coef_vec_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [ROW_W-1:0]     row_sum_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic [LINE_WORD_W-1:0]      line_word_t;
  typedef logic [COL_W-1:0]            col_addr_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel;
    logic                    frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_sum;
    logic                    frame_last;
  } out_item_t;

  // One window column on its way from the line memory to the MAC.
  typedef struct packed {
    logic    emit;
    logic    last;
    column_t column;
  } col_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_WORD_0  = 3'd2,
    REG_COEF_WORD_1  = 3'd3,
    REG_COEF_WORD_2  = 3'd4
  } cfg_reg_t;

  // Coefficient i in row-major order, four to a 64-bit word.
  function automatic pix_t coef_at(input int unsigned i,
                                   input logic [CFG_DATA_W-1:0] w0,
                                   input logic [CFG_DATA_W-1:0] w1,
                                   input logic [PIX_W-1:0] w2);
    pix_t res;
    if (i < 4) begin
      res = w0[PIX_W*i +: PIX_W];
    end else if (i < 8) begin
      res = w1[PIX_W*(i-4) +: PIX_W];
    end else begin
      res = w2;
    end
    return res;
  endfunction

endpackage

/* src/valid_2d_convolution_top.sv */
// ----------------------------------------------------------------------------
// valid_2d_convolution_top: streaming 3x3 valid convolution
// Raster-order Q4.12 pixels in, one exact Q16.24 window sum out for every
// window that lies fully inside the image.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_data   (pixel, frame_start)
//   out      output     out_valid / out_ready out_data  (conv_sum, frame_last)
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item is accepted per cycle while in_ready is high; the line memory has one read
// and one write port and each item uses each once. A result reaches the output
// register through the window (loaded with the memory read data), the multiply,
// the row sums and the total. Synchronous reset clears the line memory valid
// bits at once, so there is no clearing pass. A stalled output fills the
// pipeline's empty stages before in_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module valid_2d_convolution_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vcv_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vcv_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vcv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vcv_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int K = vcv_pkg::KERNEL_SIZE;

  // Configuration registers
  logic [vcv_pkg::WIDTH_W-1:0]    image_width;
  logic [vcv_pkg::HEIGHT_W-1:0]   image_height;
  logic [vcv_pkg::CFG_DATA_W-1:0] coef_word_0;
  logic [vcv_pkg::CFG_DATA_W-1:0] coef_word_1;
  logic [vcv_pkg::PIX_W-1:0]      coef_word_2;
  vcv_pkg::coef_vec_t             coef;

  // Position counters
  vcv_pkg::col_addr_t             column_count;
  logic [vcv_pkg::HEIGHT_W-1:0]   row_count;
  vcv_pkg::col_addr_t             col_cur;
  logic [vcv_pkg::HEIGHT_W-1:0]   row_cur;
  logic [vcv_pkg::WIDTH_W-1:0]    w_eff;
  logic [vcv_pkg::HEIGHT_W-1:0]   h_eff;
  logic                           col_wrap;
  logic                           emit_cur;
  logic                           last_cur;

  // Stage 1: item waiting on its line memory read
  logic                           s1_valid;
  vcv_pkg::pix_t                  s1_px;
  vcv_pkg::col_addr_t             s1_col;
  logic                           s1_emit;
  logic                           s1_last;

  logic                           in_fire;
  logic                           mac_ready;
  logic                           wr_en;
  vcv_pkg::line_word_t            rd_word;
  vcv_pkg::line_word_t            wr_word;
  vcv_pkg::col_item_t             mac_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= vcv_pkg::WIDTH_W'(28);
      image_height <= vcv_pkg::HEIGHT_W'(28);
      coef_word_0  <= '0;
      coef_word_1  <= '0;
      coef_word_2  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vcv_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[vcv_pkg::WIDTH_W-1:0];
        vcv_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[vcv_pkg::HEIGHT_W-1:0];
        vcv_pkg::REG_COEF_WORD_0:  coef_word_0  <= cfg_data;
        vcv_pkg::REG_COEF_WORD_1:  coef_word_1  <= cfg_data;
        vcv_pkg::REG_COEF_WORD_2:  coef_word_2  <= cfg_data[vcv_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < vcv_pkg::TAPS; i++) begin
      coef[i] = vcv_pkg::coef_at(i, coef_word_0, coef_word_1, coef_word_2);
    end
  end

  // Clamped frame geometry.
  always_comb begin
    if (image_width < vcv_pkg::WIDTH_W'(K)) begin
      w_eff = vcv_pkg::WIDTH_W'(K);
    end else if (image_width > vcv_pkg::WIDTH_W'(vcv_pkg::MAX_WIDTH)) begin
      w_eff = vcv_pkg::WIDTH_W'(vcv_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height < vcv_pkg::HEIGHT_W'(K)) begin
      h_eff = vcv_pkg::HEIGHT_W'(K);
    end else begin
      h_eff = image_height;
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign in_ready = !s1_valid || mac_ready;

  always_comb begin
    col_cur  = in_data.frame_start ? '0 : column_count;
    row_cur  = in_data.frame_start ? '0 : row_count;
    emit_cur = (row_cur >= vcv_pkg::HEIGHT_W'(K - 1)) &&
               (col_cur >= vcv_pkg::COL_W'(K - 1));
    col_wrap = vcv_pkg::WIDTH_W'(col_cur) >= (w_eff - vcv_pkg::WIDTH_W'(1));
    last_cur = (row_cur == (h_eff - vcv_pkg::HEIGHT_W'(1))) &&
               (vcv_pkg::WIDTH_W'(col_cur) == (w_eff - vcv_pkg::WIDTH_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (in_fire) begin
        if (col_wrap) begin
          column_count <= '0;
          if (row_cur >= (h_eff - vcv_pkg::HEIGHT_W'(1))) begin
            row_count <= '0;
          end else begin
            row_count <= row_cur + vcv_pkg::HEIGHT_W'(1);
          end
        end else begin
          column_count <= col_cur + vcv_pkg::COL_W'(1);
          row_count    <= row_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px   <= in_data.pixel;
      s1_col  <= col_cur;
      s1_emit <= emit_cur;
      s1_last <= last_cur;
    end
  end

  // Column for the window: buffered rows oldest first, the new pixel last.
  // The memory word moves up one row and takes the new pixel on top.
  always_comb begin
    for (int r = 0; r < vcv_pkg::LINES; r++) begin
      mac_item.column[r] = rd_word[r*vcv_pkg::PIX_W +: vcv_pkg::PIX_W];
    end
    mac_item.column[K-1] = s1_px;
    mac_item.emit        = s1_emit;
    mac_item.last        = s1_last;
    for (int r = 0; r < vcv_pkg::LINES - 1; r++) begin
      wr_word[r*vcv_pkg::PIX_W +: vcv_pkg::PIX_W] =
        rd_word[(r+1)*vcv_pkg::PIX_W +: vcv_pkg::PIX_W];
    end
    wr_word[(vcv_pkg::LINES-1)*vcv_pkg::PIX_W +: vcv_pkg::PIX_W] = s1_px;
  end

  assign wr_en = s1_valid && mac_ready;

  vcv_line_mem u_line_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (col_cur),
    .rd_word (rd_word),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_word (wr_word)
  );

  vcv_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s1_valid),
    .item_ready (mac_ready),
    .item       (mac_item),
    .coef       (coef),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_frame_start_pos: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.frame_start
    |=> (column_count == vcv_pkg::COL_W'(1)) && (row_count == '0))
    else $error("frame start did not restart the position counters");

endmodule

/* src/vcv_line_mem.sv */
// ----------------------------------------------------------------------------
// vcv_line_mem: line buffer memory
// One word per column holds all buffered rows. Synchronous registered read,
// same-cycle write forwarding, and per-entry valid bits so
// that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module vcv_line_mem (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  vcv_pkg::col_addr_t  rd_addr,
  output vcv_pkg::line_word_t rd_word,
  input  logic                wr_en,
  input  vcv_pkg::col_addr_t  wr_addr,
  input  vcv_pkg::line_word_t wr_word
);

  vcv_pkg::line_word_t         mem [vcv_pkg::MAX_WIDTH];
  logic [vcv_pkg::MAX_WIDTH-1:0] line_valid;
  vcv_pkg::line_word_t         rd_raw;
  logic                        rd_vld;
  logic                        byp_hit;
  vcv_pkg::line_word_t         byp_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
      rd_vld     <= 1'b0;
      byp_hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        line_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld  <= line_valid[rd_addr];
        byp_hit <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // A write to the entry being read in the same cycle wins over the old data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_word <= wr_word;
    end
  end

  assign rd_word = byp_hit ? byp_word : (rd_vld ? rd_raw : '0);

  a_forward: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr_en && (rd_addr == wr_addr) |=> rd_word == $past(wr_word))
    else $error("line memory lost a same-cycle write");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    rd_en && !line_valid[rd_addr] && !(wr_en && (wr_addr == rd_addr))
    |=> rd_word == '0)
    else $error("unwritten line entry did not read as zero");

endmodule

/* src/vcv_mac.sv */
// ----------------------------------------------------------------------------
// vcv_mac: window register and multiply-accumulate pipeline
// Shifts each column into the KxK window, multiplies all taps, sums per row,
// then sums the rows into the output register.
// ----------------------------------------------------------------------------
module vcv_mac (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  vcv_pkg::col_item_t  item,
  input  vcv_pkg::coef_vec_t  coef,
  output logic                out_valid,
  input  logic                out_ready,
  output vcv_pkg::out_item_t  out_data
);

  localparam int K = vcv_pkg::KERNEL_SIZE;

  vcv_pkg::pix_t     window [K][K];
  vcv_pkg::prod_t    prod   [K][K];
  vcv_pkg::row_sum_t row_sum [K];
  vcv_pkg::row_sum_t row_sum_next [K];
  vcv_pkg::sum_t     sum_next;

  logic v2, e2, l2;
  logic v3, l3;
  logic v4, l4;
  logic ld2, ld3, ld4, ld_out;

  // Each stage loads when it is empty or the stage after it moves on.
  assign ld_out     = !out_valid || out_ready;
  assign ld4        = !v4 || ld_out;
  assign ld3        = !v3 || ld4;
  assign ld2        = !v2 || ld3;
  assign item_ready = ld2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
      for (int r = 0; r < K; r++) begin
        for (int c = 0; c < K; c++) begin
          window[r][c] <= '0;
        end
      end
    end else begin
      if (ld2) begin
        v2 <= item_valid;
        if (item_valid) begin
          for (int r = 0; r < K; r++) begin
            for (int c = 0; c < K - 1; c++) begin
              window[r][c] <= window[r][c+1];
            end
            window[r][K-1] <= item.column[r];
          end
        end
      end
      if (ld3) begin
        v3 <= v2 && e2;
      end
      if (ld4) begin
        v4 <= v3;
      end
      if (ld_out) begin
        out_valid <= v4;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < K; r++) begin
      row_sum_next[r] = '0;
      for (int c = 0; c < K; c++) begin
        row_sum_next[r] = row_sum_next[r] + vcv_pkg::row_sum_t'(prod[r][c]);
      end
    end
    sum_next = '0;
    for (int r = 0; r < K; r++) begin
      sum_next = sum_next + vcv_pkg::sum_t'(row_sum[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      e2 <= item.emit;
      l2 <= item.last;
    end
    if (ld3) begin
      l3 <= l2;
      for (int r = 0; r < K; r++) begin
        for (int c = 0; c < K; c++) begin
          prod[r][c] <= $signed(window[r][c]) * $signed(coef[r*K+c]);
        end
      end
    end
    if (ld4) begin
      l4 <= l3;
      for (int r = 0; r < K; r++) begin
        row_sum[r] <= row_sum_next[r];
      end
    end
    if (ld_out) begin
      out_data.conv_sum   <= sum_next;
      out_data.frame_last <= l4;
    end
  end

  a_emit_reaches_mult: assert property (@(posedge clk) disable iff (rst)
    v2 && e2 && ld3 |=> v3)
    else $error("emitting window was dropped before the multipliers");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v4))
    else $error("result appeared without a summed item behind it");

endmodule

/* tb/sv/valid_2d_convolution_top_tb.sv */
// ----------------------------------------------------------------------------
// valid_2d_convolution_top_tb: self-checking bench for the 3x3 valid convolution
// Streams raster-order pixels through the block under several image sizes and
// kernels, predicts every window sum and end-of-frame flag in a scoreboard
// class, and compares each result item in order. Both channels idle at random,
// and the output is once held off long enough to back up the input.
// ----------------------------------------------------------------------------
module valid_2d_convolution_top_tb;

  localparam int RANDOM_ITEMS  = 2000;
  localparam int MAX_GAP       = 12;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_AT       = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int STREAM_MARGIN = 60;

  class conv_scoreboard;
    logic [vcv_pkg::WIDTH_W-1:0]    width_reg;
    logic [vcv_pkg::HEIGHT_W-1:0]   height_reg;
    logic [vcv_pkg::CFG_DATA_W-1:0] coef_lo;
    logic [vcv_pkg::CFG_DATA_W-1:0] coef_hi;
    logic [vcv_pkg::PIX_W-1:0]      coef_last;
    vcv_pkg::pix_t       line_mem [vcv_pkg::LINES][vcv_pkg::MAX_WIDTH];
    vcv_pkg::pix_t       win [vcv_pkg::KERNEL_SIZE][vcv_pkg::KERNEL_SIZE];
    int unsigned         col_cnt;
    int unsigned         row_cnt;
    vcv_pkg::out_item_t  sums_due [$];
    int                  errors;

    function new();
      width_reg  = 7'd28;
      height_reg = 16'd28;
      coef_lo    = '0;
      coef_hi    = '0;
      coef_last  = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      errors     = 0;
      for (int r = 0; r < vcv_pkg::LINES; r++)
        for (int c = 0; c < vcv_pkg::MAX_WIDTH; c++) line_mem[r][c] = '0;
      for (int r = 0; r < vcv_pkg::KERNEL_SIZE; r++)
        for (int c = 0; c < vcv_pkg::KERNEL_SIZE; c++) win[r][c] = '0;
    endfunction

    function void write_reg(logic [vcv_pkg::CFG_IDX_W-1:0] idx,
                            logic [vcv_pkg::CFG_DATA_W-1:0] data);
      unique case (idx)
        vcv_pkg::REG_IMAGE_WIDTH:  width_reg  = data[vcv_pkg::WIDTH_W-1:0];
        vcv_pkg::REG_IMAGE_HEIGHT: height_reg = data[vcv_pkg::HEIGHT_W-1:0];
        vcv_pkg::REG_COEF_WORD_0:  coef_lo    = data;
        vcv_pkg::REG_COEF_WORD_1:  coef_hi    = data;
        vcv_pkg::REG_COEF_WORD_2:  coef_last  = data[vcv_pkg::PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function int tap_value(int i);
      logic [vcv_pkg::PIX_W-1:0] raw;
      if (i < 4) raw = coef_lo[vcv_pkg::PIX_W*i +: vcv_pkg::PIX_W];
      else if (i < 8) raw = coef_hi[vcv_pkg::PIX_W*(i-4) +: vcv_pkg::PIX_W];
      else raw = coef_last;
      return int'($signed(raw));
    endfunction

    function bit at_origin();
      return (col_cnt == 0) && (row_cnt == 0);
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    function void note_pixel(vcv_pkg::in_item_t item);
      int unsigned        w;
      int unsigned        h;
      int unsigned        col;
      vcv_pkg::pix_t      column [vcv_pkg::KERNEL_SIZE];
      longint             acc;
      vcv_pkg::out_item_t due;
      w = width_reg;
      if (w < vcv_pkg::KERNEL_SIZE) w = vcv_pkg::KERNEL_SIZE;
      if (w > vcv_pkg::MAX_WIDTH) w = vcv_pkg::MAX_WIDTH;
      h = height_reg;
      if (h < vcv_pkg::KERNEL_SIZE) h = vcv_pkg::KERNEL_SIZE;
      if (item.frame_start) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      col = (col_cnt >= vcv_pkg::MAX_WIDTH) ? vcv_pkg::MAX_WIDTH - 1 : col_cnt;
      // Older rows come out of the line memory, the new pixel closes the column.
      for (int r = 0; r < vcv_pkg::LINES; r++) column[r] = line_mem[r][col];
      column[vcv_pkg::KERNEL_SIZE-1] = item.pixel;
      for (int r = 0; r + 1 < vcv_pkg::LINES; r++) line_mem[r][col] = line_mem[r+1][col];
      line_mem[vcv_pkg::LINES-1][col] = item.pixel;
      for (int r = 0; r < vcv_pkg::KERNEL_SIZE; r++) begin
        for (int c = 0; c + 1 < vcv_pkg::KERNEL_SIZE; c++) win[r][c] = win[r][c+1];
        win[r][vcv_pkg::KERNEL_SIZE-1] = column[r];
      end
      if (row_cnt >= vcv_pkg::KERNEL_SIZE - 1 && col_cnt >= vcv_pkg::KERNEL_SIZE - 1) begin
        acc = 0;
        for (int r = 0; r < vcv_pkg::KERNEL_SIZE; r++)
          for (int c = 0; c < vcv_pkg::KERNEL_SIZE; c++)
            acc += longint'($signed(win[r][c])) *
                   longint'(tap_value(r*vcv_pkg::KERNEL_SIZE + c));
        due.conv_sum   = acc[vcv_pkg::SUM_W-1:0];
        due.frame_last = (row_cnt == h - 1) && (col_cnt == w - 1);
        sums_due.insert(sums_due.size(), due);
      end
      if (col_cnt >= w - 1) begin
        col_cnt = 0;
        if (row_cnt >= h - 1) row_cnt = 0;
        else row_cnt = (row_cnt + 1) & 32'hFFFF;
      end else begin
        col_cnt++;
      end
    endfunction

    function void check_result(vcv_pkg::out_item_t got);
      vcv_pkg::out_item_t due;
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected result item, actual conv_sum %0d frame_last %0b",
                 $time, got.conv_sum, got.frame_last);
        errors++;
        return;
      end
      due = sums_due.pop_front();
      if (got.conv_sum !== due.conv_sum) begin
        $display("%0t: conv_sum mismatch, expected %0d, actual %0d",
                 $time, due.conv_sum, got.conv_sum);
        errors++;
      end
      if (got.frame_last !== due.frame_last) begin
        $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                 $time, due.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  vcv_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  vcv_pkg::out_item_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [vcv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [vcv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  conv_scoreboard sb = new();
  bit calm = 1'b0;
  bit streaming = 1'b0;
  bit held = 1'b0;

  valid_2d_convolution_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_pixel(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic write_cfg(input logic [vcv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vcv_pkg::CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_pixel(input vcv_pkg::pix_t px, input bit fs);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{pixel: px, frame_start: fs};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // The block may still hold items that make no result once the queue is empty.
  task automatic drain_pipeline();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [vcv_pkg::CFG_DATA_W-1:0] noisy_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [vcv_pkg::CFG_DATA_W-1:0] pick_coef_word();
    unique case ($urandom_range(0, 4))
      0:       return {4{16'h8000}};
      1:       return {4{16'h7FFF}};
      2:       return '0;
      default: return noisy_word();
    endcase
  endfunction

  function automatic logic [vcv_pkg::WIDTH_W-1:0] pick_width();
    unique case ($urandom_range(0, 9))
      0:       return vcv_pkg::WIDTH_W'($urandom_range(0, 2));
      1:       return vcv_pkg::WIDTH_W'($urandom_range(vcv_pkg::MAX_WIDTH, 127));
      2:       return vcv_pkg::WIDTH_W'($urandom_range(vcv_pkg::KERNEL_SIZE,
                                                       vcv_pkg::MAX_WIDTH));
      default: return vcv_pkg::WIDTH_W'($urandom_range(vcv_pkg::KERNEL_SIZE, 10));
    endcase
  endfunction

  function automatic logic [vcv_pkg::HEIGHT_W-1:0] pick_height();
    unique case ($urandom_range(0, 9))
      0:       return vcv_pkg::HEIGHT_W'($urandom_range(0, 2));
      1:       return 16'hFFFF;
      2:       return vcv_pkg::HEIGHT_W'($urandom_range(9, 65535));
      default: return vcv_pkg::HEIGHT_W'($urandom_range(vcv_pkg::KERNEL_SIZE, 8));
    endcase
  endfunction

  function automatic vcv_pkg::pix_t pick_pixel();
    unique case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return vcv_pkg::PIX_W'($urandom());
    endcase
  endfunction

  task automatic write_size(input logic [vcv_pkg::WIDTH_W-1:0] w,
                            input logic [vcv_pkg::HEIGHT_W-1:0] h);
    logic [vcv_pkg::CFG_DATA_W-1:0] word;
    // Upper data bits carry noise; only the register's own width is kept.
    word = noisy_word();
    word[vcv_pkg::WIDTH_W-1:0] = w;
    write_cfg(vcv_pkg::REG_IMAGE_WIDTH, word);
    word = noisy_word();
    word[vcv_pkg::HEIGHT_W-1:0] = h;
    write_cfg(vcv_pkg::REG_IMAGE_HEIGHT, word);
  endtask

  task automatic write_kernel(input logic [vcv_pkg::CFG_DATA_W-1:0] w0,
                              input logic [vcv_pkg::CFG_DATA_W-1:0] w1,
                              input logic [vcv_pkg::PIX_W-1:0] w2);
    logic [vcv_pkg::CFG_DATA_W-1:0] word;
    write_cfg(vcv_pkg::REG_COEF_WORD_0, w0);
    write_cfg(vcv_pkg::REG_COEF_WORD_1, w1);
    word = noisy_word();
    word[vcv_pkg::PIX_W-1:0] = w2;
    write_cfg(vcv_pkg::REG_COEF_WORD_2, word);
  endtask

  // Receiver: random stall before every result, plus one long hold-off taken
  // while the sender still has plenty of items left to offer.
  initial begin
    int gap;
    int taken;
    taken = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (!held && taken >= HOLD_AT && streaming) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    int sent;
    int phase;
    int count;
    bit fs;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Largest positive sum: most negative pixels against most negative taps.
    calm = 1'b1;
    write_size(7'd3, 16'd3);
    write_kernel({4{16'h8000}}, {4{16'h8000}}, 16'h8000);
    for (int i = 0; i < 9; i++) send_pixel(16'h8000, i == 0);
    drain_pipeline();

    // Width and height below the kernel size get clamped; the frame wraps on
    // its own, and the most negative sum comes out.
    write_size(7'd0, 16'd1);
    write_kernel({4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
    write_cfg(vcv_pkg::CFG_IDX_W'(int'(vcv_pkg::REG_COEF_WORD_2) + $urandom_range(1, 3)),
              noisy_word());
    for (int i = 0; i < 9; i++) send_pixel(16'h8000, 1'b0);
    // A frame start in the middle of a frame restarts the position.
    send_pixel(16'h7FFF, 1'b0);
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'h7FFF, 1'b1);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    drain_pipeline();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      unique case (phase)
        0: write_size(7'd64, 16'd4);
        1: write_size(7'd127, 16'hFFFF);
        2: write_size(7'd1, 16'd2);
        3: write_size(7'd3, 16'd0);
        default: begin
          if ($urandom_range(0, 1)) write_size(pick_width(), pick_height());
        end
      endcase
      if (phase == 0 || $urandom_range(0, 1))
        write_kernel(pick_coef_word(), pick_coef_word(),
                     vcv_pkg::PIX_W'(pick_coef_word()));
      if ($urandom_range(0, 9) == 0)
        write_cfg(vcv_pkg::CFG_IDX_W'(int'(vcv_pkg::REG_COEF_WORD_2) +
                                      $urandom_range(1, 3)), noisy_word());
      count = $urandom_range(40, 250);
      for (int j = 0; j < count; j++) begin
        streaming = (count - j > STREAM_MARGIN);
        // Mostly proper frames; now and then a frame start out of place.
        if (sb.at_origin()) fs = $urandom_range(0, 1);
        else fs = ($urandom_range(0, 79) == 0);
        send_pixel(pick_pixel(), fs);
        sent++;
      end
      streaming = 1'b0;
      drain_pipeline();
      phase++;
    end

    if (sb.errors == 0) begin
      $display("valid_2d_convolution_top_tb: done, clean");
    end else begin
      $display("valid_2d_convolution_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("valid_2d_convolution_top_tb: done, errors");
    $finish;
  end

endmodule

/* valid_2d_convolution_top.f */
src/vcv_pkg.sv
src/vcv_line_mem.sv
src/vcv_mac.sv
src/valid_2d_convolution_top.sv
tb/sv/valid_2d_convolution_top_tb.sv
